// ===== hdl/mocst_pkg.sv =====
`default_nettype none

package mocst_pkg;

   // default coordinate width
   localparam int unsigned COORD_BITS_DEF = 16;

   // motion fractions are unsigned q1.8
   localparam int unsigned FRAC_BITS = 9;
   localparam int unsigned FRAC_SHIFT = 8;

   localparam logic [FRAC_BITS-1:0] MIN_FRAC_RESET = 9'd64;
   localparam logic [FRAC_BITS-1:0] MAX_FRAC_RESET = 9'd256;

   // csr register indexes
   localparam int unsigned CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_MOTION = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_MOTION = 1'd1;

   // reject codes, first failing test wins
   typedef enum logic [2:0] {
      REJ_NONE         = 3'd0,
      REJ_EMPTY        = 3'd1,
      REJ_LEFT         = 3'd2,
      REJ_RIGHT        = 3'd3,
      REJ_FIRST_SHORT  = 3'd4,
      REJ_FIRST_LONG   = 3'd5,
      REJ_SECOND_SHORT = 3'd6,
      REJ_SECOND_LONG  = 3'd7
   } reject_type;

endpackage

`default_nettype wire

// ===== hdl/moving_object_cluster_test_unit.sv =====
`default_nettype none

// Moving object test for one cluster of strips. Strips stream in one request
// per cycle; each folds its center into the newer and/or older bounding box.
// The request with req_last_strip set also carries the cluster's leftmost and
// rightmost x, and produces exactly one response: both boxes (swapped so the
// motion runs left to right), a reject code and is_object. Other requests
// produce no response. Both boxes clear after the last strip.
// A request reaches the response through the input register, then the
// result register; throughput is one request per cycle, limited only by the
// single result register when the response side stalls on a last strip.
// Motion bounds are csr fractions in unsigned q1.8 of the cluster width,
// truncated toward zero. csr writes are taken at any time, csr_ready is
// always high, and should happen only while the block is idle.
module moving_object_cluster_test_unit
   import mocst_pkg::*;
#(
   parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,

   // csr write port
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [CSR_INDEX_BITS-1:0]       csr_index,
   input  wire  [FRAC_BITS-1:0]            csr_data,

   // strip requests
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire  signed [COORD_BITS-1:0]    req_strip_x,
   input  wire  signed [COORD_BITS-1:0]    req_strip_y,
   input  wire                             req_in_newer,
   input  wire                             req_in_older,
   input  wire  signed [COORD_BITS-1:0]    req_cluster_left_x,
   input  wire  signed [COORD_BITS-1:0]    req_cluster_right_x,
   input  wire                             req_last_strip,

   // cluster responses
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic                            rsp_is_object,
   output logic [2:0]                      rsp_reject_code,
   output logic signed [COORD_BITS-1:0]    rsp_first_min_x,
   output logic signed [COORD_BITS-1:0]    rsp_first_min_y,
   output logic signed [COORD_BITS-1:0]    rsp_first_max_x,
   output logic signed [COORD_BITS-1:0]    rsp_first_max_y,
   output logic signed [COORD_BITS-1:0]    rsp_second_min_x,
   output logic signed [COORD_BITS-1:0]    rsp_second_min_y,
   output logic signed [COORD_BITS-1:0]    rsp_second_max_x,
   output logic signed [COORD_BITS-1:0]    rsp_second_max_y
);

   localparam int unsigned CB = COORD_BITS;
   // width and motion distances need one extra bit
   localparam int unsigned DW = CB + 1;
   // product of a q1.8 fraction (zero-extended) and the width
   localparam int unsigned PW = DW + FRAC_BITS + 1;
   // bound after dropping the fraction bits
   localparam int unsigned LW = PW - FRAC_SHIFT;

   localparam logic signed [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] COORD_MIN = {1'b1, {(CB-1){1'b0}}};
   localparam logic signed [PW-1:0] ROUND_ADJ = PW'((1 << FRAC_SHIFT) - 1);

   // csr registers
   logic [FRAC_BITS-1:0] min_frac_ff;
   logic [FRAC_BITS-1:0] max_frac_ff;

   // input register
   logic                 s1_vld_ff;
   logic signed [CB-1:0] s1_x_ff;
   logic signed [CB-1:0] s1_y_ff;
   logic                 s1_newer_ff;
   logic                 s1_older_ff;
   logic signed [CB-1:0] s1_left_ff;
   logic signed [CB-1:0] s1_right_ff;
   logic                 s1_last_ff;

   // bounding boxes
   logic                 nb_vld_ff, ob_vld_ff;
   logic signed [CB-1:0] nb_min_x_ff, nb_min_y_ff, nb_max_x_ff, nb_max_y_ff;
   logic signed [CB-1:0] ob_min_x_ff, ob_min_y_ff, ob_max_x_ff, ob_max_y_ff;

   // boxes with the current strip folded in
   logic                 nb_vld_in, ob_vld_in;
   logic signed [CB-1:0] nb_min_x_in, nb_min_y_in, nb_max_x_in, nb_max_y_in;
   logic signed [CB-1:0] ob_min_x_in, ob_min_y_in, ob_max_x_in, ob_max_y_in;

   // result register
   logic                 rsp_vld_ff;
   reject_type           rsp_code_ff;
   logic signed [CB-1:0] f_min_x_ff, f_min_y_ff, f_max_x_ff, f_max_y_ff;
   logic signed [CB-1:0] s_min_x_ff, s_min_y_ff, s_max_x_ff, s_max_y_ff;

   // decision path
   logic                 s1_adv;
   logic                 both_vld;
   logic                 swap;
   logic signed [CB-1:0] f_min_x, f_min_y, f_max_x, f_max_y;
   logic signed [CB-1:0] s_min_x, s_min_y, s_max_x, s_max_y;
   logic signed [DW-1:0] width;
   logic signed [DW-1:0] motion1, motion2;
   logic signed [PW-1:0] width_ext;
   logic signed [PW-1:0] min_op, max_op;
   logic signed [PW-1:0] min_prod, max_prod;
   logic signed [PW-1:0] min_adj, max_adj;
   logic signed [LW-1:0] lo_bound, hi_bound;
   logic signed [LW-1:0] motion1_ext, motion2_ext;
   reject_type           code;

   // --------------------------------------------------------------
   // handshakes
   // --------------------------------------------------------------

   // a last strip needs the result register free; other strips always move
   assign s1_adv    = s1_vld_ff && (!s1_last_ff || !rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_adv;
   assign csr_ready = 1'b1;

   // --------------------------------------------------------------
   // box update with the strip in the input register
   // --------------------------------------------------------------

   always_comb begin
      nb_vld_in   = nb_vld_ff   || s1_newer_ff;
      nb_min_x_in = (s1_newer_ff && s1_x_ff < nb_min_x_ff) ? s1_x_ff : nb_min_x_ff;
      nb_min_y_in = (s1_newer_ff && s1_y_ff < nb_min_y_ff) ? s1_y_ff : nb_min_y_ff;
      nb_max_x_in = (s1_newer_ff && s1_x_ff > nb_max_x_ff) ? s1_x_ff : nb_max_x_ff;
      nb_max_y_in = (s1_newer_ff && s1_y_ff > nb_max_y_ff) ? s1_y_ff : nb_max_y_ff;

      ob_vld_in   = ob_vld_ff   || s1_older_ff;
      ob_min_x_in = (s1_older_ff && s1_x_ff < ob_min_x_ff) ? s1_x_ff : ob_min_x_ff;
      ob_min_y_in = (s1_older_ff && s1_y_ff < ob_min_y_ff) ? s1_y_ff : ob_min_y_ff;
      ob_max_x_in = (s1_older_ff && s1_x_ff > ob_max_x_ff) ? s1_x_ff : ob_max_x_ff;
      ob_max_y_in = (s1_older_ff && s1_y_ff > ob_max_y_ff) ? s1_y_ff : ob_max_y_ff;
   end

   // --------------------------------------------------------------
   // decision on the last strip
   // --------------------------------------------------------------

   always_comb begin
      both_vld = nb_vld_in && ob_vld_in;
      // newer box must start at the left end, else motion ran right to left
      swap     = both_vld && (nb_min_x_in != s1_left_ff);

      f_min_x = swap ? ob_min_x_in : nb_min_x_in;
      f_min_y = swap ? ob_min_y_in : nb_min_y_in;
      f_max_x = swap ? ob_max_x_in : nb_max_x_in;
      f_max_y = swap ? ob_max_y_in : nb_max_y_in;
      s_min_x = swap ? nb_min_x_in : ob_min_x_in;
      s_min_y = swap ? nb_min_y_in : ob_min_y_in;
      s_max_x = swap ? nb_max_x_in : ob_max_x_in;
      s_max_y = swap ? nb_max_y_in : ob_max_y_in;

      // cluster width, may be negative when the ends are reversed
      width     = {s1_right_ff[CB-1], s1_right_ff} - {s1_left_ff[CB-1], s1_left_ff};
      width_ext = {{(PW-DW){width[DW-1]}}, width};
      min_op    = {{(PW-FRAC_BITS){1'b0}}, min_frac_ff};
      max_op    = {{(PW-FRAC_BITS){1'b0}}, max_frac_ff};
      min_prod  = min_op * width_ext;
      max_prod  = max_op * width_ext;

      // truncate toward zero: bias negative products before the shift
      min_adj  = min_prod[PW-1] ? (min_prod + ROUND_ADJ) : min_prod;
      max_adj  = max_prod[PW-1] ? (max_prod + ROUND_ADJ) : max_prod;
      lo_bound = min_adj[PW-1:FRAC_SHIFT];
      hi_bound = max_adj[PW-1:FRAC_SHIFT];

      motion1     = {s1_right_ff[CB-1], s1_right_ff} - {f_max_x[CB-1], f_max_x};
      motion2     = {s_min_x[CB-1], s_min_x} - {s1_left_ff[CB-1], s1_left_ff};
      motion1_ext = {{(LW-DW){motion1[DW-1]}}, motion1};
      motion2_ext = {{(LW-DW){motion2[DW-1]}}, motion2};

      if (!both_vld) begin
         code = REJ_EMPTY;
      end else if (f_min_x != s1_left_ff) begin
         code = REJ_LEFT;
      end else if (s_max_x != s1_right_ff) begin
         code = REJ_RIGHT;
      end else if (motion1_ext < lo_bound) begin
         code = REJ_FIRST_SHORT;
      end else if (motion1_ext > hi_bound) begin
         code = REJ_FIRST_LONG;
      end else if (motion2_ext < lo_bound) begin
         code = REJ_SECOND_SHORT;
      end else if (motion2_ext > hi_bound) begin
         code = REJ_SECOND_LONG;
      end else begin
         code = REJ_NONE;
      end
   end

   // --------------------------------------------------------------
   // registers
   // --------------------------------------------------------------

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_frac_ff <= MIN_FRAC_RESET;
         max_frac_ff <= MAX_FRAC_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_MOTION: min_frac_ff <= csr_data;
            CSR_MAX_MOTION: max_frac_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_x_ff     <= req_strip_x;
         s1_y_ff     <= req_strip_y;
         s1_newer_ff <= req_in_newer;
         s1_older_ff <= req_in_older;
         s1_left_ff  <= req_cluster_left_x;
         s1_right_ff <= req_cluster_right_x;
         s1_last_ff  <= req_last_strip;
      end
   end

   // boxes: fold in each strip, clear after the last one
   always_ff @(posedge clock) begin
      if (reset || (s1_adv && s1_last_ff)) begin
         nb_vld_ff   <= 1'b0;
         nb_min_x_ff <= COORD_MAX;
         nb_min_y_ff <= COORD_MAX;
         nb_max_x_ff <= COORD_MIN;
         nb_max_y_ff <= COORD_MIN;
         ob_vld_ff   <= 1'b0;
         ob_min_x_ff <= COORD_MAX;
         ob_min_y_ff <= COORD_MAX;
         ob_max_x_ff <= COORD_MIN;
         ob_max_y_ff <= COORD_MIN;
      end else if (s1_adv) begin
         nb_vld_ff   <= nb_vld_in;
         nb_min_x_ff <= nb_min_x_in;
         nb_min_y_ff <= nb_min_y_in;
         nb_max_x_ff <= nb_max_x_in;
         nb_max_y_ff <= nb_max_y_in;
         ob_vld_ff   <= ob_vld_in;
         ob_min_x_ff <= ob_min_x_in;
         ob_min_y_ff <= ob_min_y_in;
         ob_max_x_ff <= ob_max_x_in;
         ob_max_y_ff <= ob_max_y_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_adv && s1_last_ff) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_last_ff) begin
         rsp_code_ff <= code;
         f_min_x_ff  <= f_min_x;
         f_min_y_ff  <= f_min_y;
         f_max_x_ff  <= f_max_x;
         f_max_y_ff  <= f_max_y;
         s_min_x_ff  <= s_min_x;
         s_min_y_ff  <= s_min_y;
         s_max_x_ff  <= s_max_x;
         s_max_y_ff  <= s_max_y;
      end
   end

   // outputs
   assign rsp_valid        = rsp_vld_ff;
   assign rsp_is_object    = (rsp_code_ff == REJ_NONE);
   assign rsp_reject_code  = rsp_code_ff;
   assign rsp_first_min_x  = f_min_x_ff;
   assign rsp_first_min_y  = f_min_y_ff;
   assign rsp_first_max_x  = f_max_x_ff;
   assign rsp_first_max_y  = f_max_y_ff;
   assign rsp_second_min_x = s_min_x_ff;
   assign rsp_second_min_y = s_min_y_ff;
   assign rsp_second_max_x = s_max_x_ff;
   assign rsp_second_max_y = s_max_y_ff;

   // --------------------------------------------------------------
   // assertions
   // --------------------------------------------------------------

   // a new response only comes from a last strip leaving the input register
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !$past(rsp_vld_ff)) |-> $past(s1_adv && s1_last_ff))
      else $error("response without a last strip");

   // boxes are empty right after a cluster is closed
   a_box_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (!nb_vld_ff && !ob_vld_ff))
      else $error("boxes not cleared after last strip");

   // a stalled input register keeps its request
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !s1_adv) |=> (s1_vld_ff && $stable(s1_x_ff) && $stable(s1_last_ff)))
      else $error("input register lost a stalled request");

   // an accepted object has boxes whose x ranges are not inverted
   a_obj_boxes: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_code_ff == REJ_NONE) |->
         (f_min_x_ff <= f_max_x_ff && s_min_x_ff <= s_max_x_ff))
      else $error("object with an inverted box");

endmodule

`default_nettype wire
